[hdl/mcma_pkg.sv]
// ----------------------------------------------------------------------------
// mcma_pkg - shared types and constants of the moving-average block
// Request and result payloads, command codes and default sizes.
// ----------------------------------------------------------------------------
package mcma_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CHANNEL_W  = 2;
  localparam int NEW_SIZE_W = 10;
  localparam int CFG_W      = 7;

  localparam int CHANNELS_DEF         = 4;
  localparam int MAX_WINDOW_DEF       = 64;
  localparam int FALLBACK_WINDOW      = 16;
  localparam int DEFAULT_WINDOW_RESET = 16;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_RESET = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [CHANNEL_W-1:0]        channel;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [NEW_SIZE_W-1:0]       new_size;
  } in_item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]        out_channel;
    logic signed [SAMPLE_W-1:0]  average;
    logic                        window_full;
  } out_item_t;

endpackage

[hdl/mcma_ram.sv]
// ----------------------------------------------------------------------------
// mcma_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mcma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mcma_div.sv]
// ----------------------------------------------------------------------------
// mcma_div - iterative unsigned restoring divider
// One quotient bit per cycle; done pulses when the quotient is valid.
// ----------------------------------------------------------------------------
module mcma_div #(
  parameter int DIVIDEND_W = 23,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     steps;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= CNT_W'(DIVIDEND_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // shift in the next dividend bit, subtract when it fits
        rem      <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], ge};
        steps    <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/multichannel_moving_average.sv]
// ----------------------------------------------------------------------------
// multichannel_moving_average - per-channel boxcar moving average
// Sliding-window average over the last N samples of each sensor channel.
// ----------------------------------------------------------------------------
// The block keeps, for each of CHANNELS channels, a ring of up to MAX_WINDOW
// signed samples in one synchronous RAM, plus a window size, write position,
// fill count and running sum in registers. An add request reads the ring slot
// about to be overwritten, drops that oldest sample from the sum once the
// window is full, stores the new sample and divides the sum by the fill count
// (truncated toward zero) on an iterative divider. A reset request clears one
// channel and sets its window size (0 keeps the old size, larger sizes clamp
// to MAX_WINDOW). Every request gives exactly one result. One request is in
// work at a time: an add passes through the read, update, divide and done
// states, the divider producing one quotient bit per cycle; a reset or
// out-of-range channel goes from idle straight to the done state.
// The result register lets the next request be accepted while a result still
// waits on result_ready. Writing cfg_data re-initializes every channel with
// the new default window (0 selects 16, capped at MAX_WINDOW); write it only
// while the block is idle. The sample RAM needs no clearing pass: a slot's old
// value is used only after it has been written.
// ----------------------------------------------------------------------------
module multichannel_moving_average #(
  parameter int CHANNELS   = mcma_pkg::CHANNELS_DEF,
  parameter int MAX_WINDOW = mcma_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcma_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mcma_pkg::in_item_t            item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mcma_pkg::out_item_t           result
);

  import mcma_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int SIZE_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + SIZE_W;
  localparam int DEPTH  = CHANNELS * MAX_WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int INIT_SIZE_I =
    (DEFAULT_WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW_RESET;
  localparam int FALLBACK_I =
    (FALLBACK_WINDOW > MAX_WINDOW) ? MAX_WINDOW : FALLBACK_WINDOW;
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(INIT_SIZE_I);
  localparam logic [SIZE_W-1:0] FALLBACK  = SIZE_W'(FALLBACK_I);
  localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(MAX_WINDOW);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;

  // per-channel state
  logic [SIZE_W-1:0]       win_size [CHANNELS];
  logic [POS_W-1:0]        wr_pos   [CHANNELS];
  logic [SIZE_W-1:0]       fill     [CHANNELS];
  logic signed [SUM_W-1:0] run_sum  [CHANNELS];

  // request in work and its result
  in_item_t                cur;
  logic [CH_W-1:0]         cur_ch;
  logic                    neg;
  logic signed [SAMPLE_W-1:0] res_avg;
  logic                    res_full;

  // accept-side decode
  logic                    item_acc;
  logic                    in_ok;
  logic [CH_W-1:0]         in_ch;
  logic [SIZE_W-1:0]       reset_size;
  logic [SIZE_W-1:0]       cfg_size;

  // update-side arithmetic
  logic [ADDR_W-1:0]       slot;
  logic [SAMPLE_W-1:0]     old_sample;
  logic                    was_full;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] new_ext;
  logic signed [SUM_W-1:0] sum_next;
  logic [SIZE_W-1:0]       fill_next;
  logic [POS_W-1:0]        pos_next;
  logic [SUM_W-1:0]        sum_mag;

  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        quo;
  logic [SUM_W-1:0]        quo_signed;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign item_acc   = item_valid && item_ready;

  always_comb begin
    in_ok = (32'(item.channel) < CHANNELS);
    in_ch = CH_W'(item.channel);

    // clamp the requested size; zero keeps the current one
    if (32'(item.new_size) > MAX_WINDOW) begin
      reset_size = MAX_SIZE;
    end else if (item.new_size == '0) begin
      reset_size = win_size[in_ch];
    end else begin
      reset_size = SIZE_W'(item.new_size);
    end

    if (cfg_data == '0) begin
      cfg_size = FALLBACK;
    end else if (32'(cfg_data) > MAX_WINDOW) begin
      cfg_size = MAX_SIZE;
    end else begin
      cfg_size = SIZE_W'(cfg_data);
    end
  end

  always_comb begin
    slot     = ADDR_W'(32'(cur_ch) * MAX_WINDOW) + ADDR_W'(wr_pos[cur_ch]);
    was_full = (fill[cur_ch] == win_size[cur_ch]);
    old_ext  = {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
    new_ext  = {{(SUM_W-SAMPLE_W){cur.sample[SAMPLE_W-1]}}, cur.sample};
    // drop the oldest sample once the window is full
    sum_next  = run_sum[cur_ch] - (was_full ? old_ext : '0) + new_ext;
    fill_next = was_full ? win_size[cur_ch] : fill[cur_ch] + SIZE_W'(1);
    if (SIZE_W'(wr_pos[cur_ch]) + SIZE_W'(1) == win_size[cur_ch]) begin
      pos_next = '0;
    end else begin
      pos_next = wr_pos[cur_ch] + POS_W'(1);
    end
    sum_mag    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    quo_signed = neg ? SUM_W'(-quo) : quo;
    div_start  = (state == S_UPDATE);
  end

  mcma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (slot),
    .wdata (cur.sample),
    .re    (state == S_READ),
    .raddr (slot),
    .rdata (old_sample)
  );

  mcma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (SIZE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill_next),
    .done     (div_done),
    .quotient (quo)
  );

  // sequencer and per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int c = 0; c < CHANNELS; c++) begin
        win_size[c] <= INIT_SIZE;
        wr_pos[c]   <= '0;
        fill[c]     <= '0;
        run_sum[c]  <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            cur      <= item;
            cur_ch   <= in_ch;
            res_avg  <= '0;
            res_full <= 1'b0;
            if (in_ok && item.cmd == CMD_ADD) begin
              state <= S_READ;
            end else begin
              // reset requests and unknown channels answer at once
              if (in_ok) begin
                win_size[in_ch] <= reset_size;
                wr_pos[in_ch]   <= '0;
                fill[in_ch]     <= '0;
                run_sum[in_ch]  <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          run_sum[cur_ch] <= sum_next;
          fill[cur_ch]    <= fill_next;
          wr_pos[cur_ch]  <= pos_next;
          res_full        <= (fill_next == win_size[cur_ch]);
          neg             <= sum_next[SUM_W-1];
          state           <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            res_avg <= SAMPLE_W'(quo_signed);
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_valid && cfg_ready) begin
        for (int c = 0; c < CHANNELS; c++) begin
          win_size[c] <= cfg_size;
          wr_pos[c]   <= '0;
          fill[c]     <= '0;
          run_sum[c]  <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!result_valid || result_ready)) begin
        result_valid       <= 1'b1;
        result.out_channel <= cur.channel;
        result.average     <= res_avg;
        result.window_full <= res_full;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
